// File: hdl/skc_pkg.sv
// Package for the sorted key counter: sizes, transaction structs, codes.
// No dependencies.
package skc_pkg;
    localparam int CAPACITY    = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int AW          = $clog2(CAPACITY);
    localparam int TW          = AW + 1;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CORRECT = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [2:0] ST_HIT  = 3'd0;
    localparam logic [2:0] ST_NEW  = 3'd1;
    localparam logic [2:0] ST_MISS = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic REG_KEY_BYTES = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  position;
        logic [31:0] count;
        logic [63:0] corrected_key;
    } out_t;

    // One table entry as held in a cell.
    typedef struct packed {
        logic [63:0]            key;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [AW-1:0]          alias_idx;
    } entry_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic          shift_en;   // cells at index > pos take neighbor entry
        logic          wr_en;      // cell at pos loads wr_entry
        logic          cnt_inc;    // cell at pos increments count
        logic          alias_self; // every cell sets alias to own index
        logic          remap_en;   // cells with alias == remap_from take remap_to
        logic          set_alias;  // cell at pos takes alias remap_to
        logic [AW-1:0] pos;
        logic [AW-1:0] remap_from;
        logic [AW-1:0] remap_to;
        entry_t        wr_entry;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_PROBE, S_FETCH, S_DECIDE, S_CA_INIT, S_CA_HEAD,
        S_CA_CHK, S_CA_SCAN, S_OUT
    } state_t;

    function automatic logic [63:0] mask_of(input logic [3:0] kb);
        logic [3:0] b;
        logic [63:0] m;
        b = (kb == 4'd0) ? 4'd1 : ((kb > 4'd8) ? 4'd8 : kb);
        m = '0;
        for (int i = 0; i < 8; i++)
            if (i < int'(b)) m[i*8 +: 8] = 8'hff;
        return m;
    endfunction
endpackage

// File: hdl/skc_cell.sv
// One storage cell of the table chain: holds one entry.
// Depends on skc_pkg.
module skc_cell (
    input  logic               clk,
    input  logic [skc_pkg::AW-1:0] idx,
    input  skc_pkg::cell_ctl_t ctl,
    input  skc_pkg::entry_t    prev_entry,
    output skc_pkg::entry_t    entry
);
    import skc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_en && idx > ctl.pos)
            entry_next = prev_entry;
        if (ctl.wr_en && idx == ctl.pos)
            entry_next = ctl.wr_entry;
        if (ctl.cnt_inc && idx == ctl.pos && entry_reg.cnt != {COUNT_WIDTH{1'b1}})
            entry_next.cnt = entry_reg.cnt + 1'b1;
        if (ctl.alias_self)
            entry_next.alias_idx = idx;
        if (ctl.remap_en && entry_reg.alias_idx == ctl.remap_from)
            entry_next.alias_idx = ctl.remap_to;
        if (ctl.set_alias && idx == ctl.pos)
            entry_next.alias_idx = ctl.remap_to;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

// File: hdl/skc_seq.sv
// Sequencer: binary search, insert, query and correction pass over the cells.
// Depends on skc_pkg; read data arrives registered, in the cycle after its address.
module skc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  skc_pkg::in_t       in_data,
    input  logic               in_valid,
    output logic               in_stall,
    output skc_pkg::out_t      out_data,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         key_bytes,
    input  logic [4:0]         max_distance,
    input  skc_pkg::entry_t    rd_entry,
    input  skc_pkg::entry_t    rd_entry2,
    output logic [skc_pkg::AW-1:0] rd_addr,
    output logic [skc_pkg::AW-1:0] rd_addr2,
    output skc_pkg::cell_ctl_t ctl
);
    import skc_pkg::*;

    state_t state_reg, state_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [TW-1:0] i_reg, i_next, j_reg, j_next;
    logic [AW-1:0] best_reg, best_next;
    logic [COUNT_WIDTH-1:0] top_count_reg, top_count_next;
    logic [63:0] head_key_reg, head_key_next;
    logic [1:0] op_reg, op_next;
    logic [63:0] key_reg, key_next;
    out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [63:0] mask;
    logic [TW-1:0] mid;
    logic [63:0] diff;
    logic [4:0] nib_dist;

    assign mask = mask_of(key_bytes);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        diff = (head_key_reg ^ rd_entry2.key) & mask;
        nib_dist = '0;
        for (int n = 0; n < 16; n++)
            if (diff[n*4 +: 4] != 4'h0) nib_dist = nib_dist + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next;
        i_reg <= i_next; j_reg <= j_next;
        best_reg <= best_next; top_count_reg <= top_count_next;
        head_key_reg <= head_key_next;
        op_reg <= op_next; key_reg <= key_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg; total_next = total_reg;
        lo_next = lo_reg; hi_next = hi_reg; i_next = i_reg; j_next = j_reg;
        best_next = best_reg; top_count_next = top_count_reg;
        head_key_next = head_key_reg;
        op_next = op_reg; key_next = key_reg;
        out_next = out_reg; out_valid_next = out_valid_reg;
        ctl = '0;
        rd_addr = mid[AW-1:0];
        rd_addr2 = j_reg[AW-1:0];
        in_stall = 1'b1;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = out_valid_reg;
                if (in_valid && !out_valid_reg)
                begin
                    op_next = in_data.op;
                    key_next = in_data.key & mask;
                    lo_next = '0; hi_next = total_reg;
                    unique case (in_data.op)
                        OP_INSERT, OP_QUERY: state_next = S_SEARCH;
                        OP_CORRECT: state_next = S_CA_INIT;
                        default:
                        begin
                            out_next = '0; out_next.status = ST_MISS;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr = mid[AW-1:0];
                    state_next = S_PROBE;
                end
                else
                begin
                    rd_addr = lo_reg[AW-1:0];
                    state_next = S_FETCH;
                end
            end
            S_PROBE:
            begin
                if ((rd_entry.key & mask) < key_reg) lo_next = mid + 1'b1;
                else hi_next = mid;
                state_next = S_SEARCH;
            end
            S_FETCH:
            begin
                rd_addr = lo_reg[AW-1:0];
                rd_addr2 = rd_entry.alias_idx;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                out_next = '0;
                ctl.pos = lo_reg[AW-1:0];
                state_next = S_OUT;
                if (lo_reg < total_reg && (rd_entry.key & mask) == key_reg)
                begin
                    out_next.status = ST_HIT;
                    out_next.position = 10'(lo_reg);
                    if (op_reg == OP_INSERT)
                    begin
                        ctl.cnt_inc = 1'b1;
                        out_next.count = 32'((rd_entry.cnt == {COUNT_WIDTH{1'b1}}) ?
                            rd_entry.cnt : rd_entry.cnt + 1'b1);
                    end
                    else
                    begin
                        out_next.count = 32'(rd_entry.cnt);
                        out_next.corrected_key = rd_entry2.key;
                    end
                end
                else if (op_reg == OP_QUERY)
                    out_next.status = ST_MISS;
                else if (total_reg >= TW'(CAPACITY))
                    out_next.status = ST_FULL;
                else
                begin
                    ctl.shift_en = 1'b1;
                    ctl.wr_en = 1'b1;
                    ctl.wr_entry.key = key_reg;
                    ctl.wr_entry.cnt = COUNT_WIDTH'(1);
                    ctl.wr_entry.alias_idx = '0;
                    total_next = total_reg + 1'b1;
                    out_next.status = ST_NEW;
                    out_next.position = 10'(lo_reg);
                    out_next.count = 32'd1;
                end
            end
            S_CA_INIT:
            begin
                ctl.alias_self = 1'b1;
                i_next = '0;
                out_next = '0; out_next.status = ST_DONE;
                state_next = (max_distance == 5'd0) ? S_OUT : S_CA_HEAD;
            end
            S_CA_HEAD:
            begin
                rd_addr = i_reg[AW-1:0];
                if (i_reg >= total_reg)
                    state_next = S_OUT;
                else
                    state_next = S_CA_CHK;
            end
            S_CA_CHK:
            begin
                if (rd_entry.alias_idx != i_reg[AW-1:0])
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_CA_HEAD;
                end
                else
                begin
                    best_next = i_reg[AW-1:0];
                    top_count_next = rd_entry.cnt;
                    head_key_next = rd_entry.key;
                    j_next = i_reg + 1'b1;
                    rd_addr2 = j_next[AW-1:0];
                    state_next = S_CA_SCAN;
                end
            end
            S_CA_SCAN:
            begin
                if (j_reg >= total_reg)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_CA_HEAD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    rd_addr2 = j_next[AW-1:0];
                    if (nib_dist <= max_distance)
                    begin
                        ctl.pos = j_reg[AW-1:0];
                        if (top_count_reg >= rd_entry2.cnt)
                        begin
                            ctl.set_alias = 1'b1;
                            ctl.remap_to = best_reg;
                        end
                        else
                        begin
                            ctl.remap_en = 1'b1;
                            ctl.remap_from = best_reg;
                            ctl.remap_to = j_reg[AW-1:0];
                            best_next = j_reg[AW-1:0];
                            top_count_next = rd_entry2.cnt;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_data = out_reg;
    assign out_valid = out_valid_reg;
endmodule

// File: hdl/sorted_key_counter_with_clustering_top.sv
// Top level of the sorted key counter: register port, sequencer, cell chain.
// Depends on skc_pkg, skc_seq and skc_cell.
// One transaction at a time; a new one is accepted only after the previous result
// has left. An insert or query runs a binary search in which each probe passes
// through S_SEARCH and S_PROBE around the registered read of the cell chain; the
// shift of an insert moves the whole cell chain at once. A correction pass compares
// one pair per cycle, and goes straight to the result when the threshold is zero.
module sorted_key_counter_with_clustering_top (
    input  logic          clk,
    input  logic          rst_n,
    input  skc_pkg::in_t  in_data,
    input  logic          in_valid,
    output logic          in_stall,
    output skc_pkg::out_t out_data,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [4:0]    cfg_data
);
    import skc_pkg::*;

    logic [3:0] key_bytes_reg;
    logic [4:0] max_distance_reg;
    cell_ctl_t ctl;
    entry_t entries [CAPACITY];
    logic [AW-1:0] rd_addr, rd_addr2;
    entry_t rd_entry_reg, rd_entry2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg    <= 4'd8;
            max_distance_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_BYTES: key_bytes_reg <= cfg_data[3:0];
                REG_MAX_DIST:  max_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        skc_cell u_cell (
            .clk        (clk),
            .idx        (AW'(g)),
            .ctl        (ctl),
            .prev_entry (entries[(g == 0) ? 0 : g - 1]),
            .entry      (entries[g])
        );
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg  <= entries[rd_addr];
        rd_entry2_reg <= entries[rd_addr2];
    end

    skc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .out_data     (out_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_bytes    (key_bytes_reg),
        .max_distance (max_distance_reg),
        .rd_entry     (rd_entry_reg),
        .rd_entry2    (rd_entry2_reg),
        .rd_addr      (rd_addr),
        .rd_addr2     (rd_addr2),
        .ctl          (ctl)
    );
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for sorted_key_counter_with_clustering_top.
// Depends on skc_pkg and the top level; a built-in table predictor checks each result.
`timescale 1ns / 100ps

module tb;
    import skc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    in_t in_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    out_t out_data;
    logic out_valid;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    sorted_key_counter_with_clustering_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    in_t pending_q[$];
    out_t expected_q[$];
    int err_count = 0;
    bit quiet = 1'b0;

    logic [63:0] tab_key[CAPACITY];
    logic [31:0] tab_cnt[CAPACITY];
    int tab_alias[CAPACITY];
    int tab_total = 0;
    logic [3:0] cur_kb = 4'd8;
    logic [4:0] cur_dist = 5'd1;

    function automatic int width_bytes();
        if (cur_kb == 4'd0)
            return 1;
        if (cur_kb > 4'd8)
            return 8;
        return int'(cur_kb);
    endfunction

    function automatic logic [63:0] width_mask();
        int b;
        b = width_bytes();
        if (b >= 8)
            return '1;
        return (64'd1 << (8 * b)) - 64'd1;
    endfunction

    function automatic int nibble_diff(logic [63:0] a, logic [63:0] b);
        logic [63:0] x;
        int d;
        x = (a ^ b) & width_mask();
        d = 0;
        for (int n = 0; n < 2 * width_bytes(); n++)
            if (x[4*n +: 4] != 4'h0)
                d++;
        return d;
    endfunction

    function automatic int search_pos(logic [63:0] k);
        logic [63:0] m;
        int lo;
        int hi;
        int mid;
        m = width_mask();
        lo = 0;
        hi = tab_total;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if ((tab_key[mid] & m) < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic void cluster_aliases();
        int best;
        logic [31:0] lead_count;
        for (int i = 0; i < tab_total; i++)
            tab_alias[i] = i;
        if (cur_dist == 5'd0)
            return;
        for (int i = 0; i < tab_total; i++)
        begin
            if (tab_alias[i] != i)
                continue;
            best = i;
            lead_count = tab_cnt[i];
            for (int j = i + 1; j < tab_total; j++)
            begin
                if (nibble_diff(tab_key[i], tab_key[j]) > int'(cur_dist))
                    continue;
                if (lead_count >= tab_cnt[j])
                    tab_alias[j] = best;
                else
                begin
                    for (int q = 0; q < tab_total; q++)
                        if (tab_alias[q] == best)
                            tab_alias[q] = j;
                    best = j;
                    lead_count = tab_cnt[j];
                end
            end
        end
    endfunction

    function automatic out_t count_step(in_t x);
        out_t r;
        logic [63:0] m;
        logic [63:0] k;
        int p;
        r = '0;
        r.status = ST_MISS;
        m = width_mask();
        k = x.key & m;
        if (x.op == OP_INSERT)
        begin
            p = search_pos(k);
            if (p < tab_total && (tab_key[p] & m) == k)
            begin
                if (tab_cnt[p] != 32'hffff_ffff)
                    tab_cnt[p] = tab_cnt[p] + 32'd1;
                r.status = ST_HIT;
                r.position = p[9:0];
                r.count = tab_cnt[p];
            end
            else if (tab_total >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (int t = tab_total; t > p; t--)
                begin
                    tab_key[t] = tab_key[t-1];
                    tab_cnt[t] = tab_cnt[t-1];
                    tab_alias[t] = tab_alias[t-1];
                end
                tab_key[p] = k;
                tab_cnt[p] = 32'd1;
                tab_alias[p] = 0;
                tab_total++;
                r.status = ST_NEW;
                r.position = p[9:0];
                r.count = 32'd1;
            end
        end
        else if (x.op == OP_QUERY)
        begin
            p = search_pos(k);
            if (p < tab_total && (tab_key[p] & m) == k)
            begin
                r.status = ST_HIT;
                r.position = p[9:0];
                r.count = tab_cnt[p];
                r.corrected_key = tab_key[tab_alias[p] % CAPACITY];
            end
        end
        else if (x.op == OP_CORRECT)
        begin
            cluster_aliases();
            r.status = ST_DONE;
        end
        return r;
    endfunction

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    int gap_left = 0;
    bit holding;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = draw_wait();
        end
        else
        begin
            holding = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(count_step(in_data));
                holding = 1'b0;
                gap_left = draw_wait();
            end
            if (!holding)
            begin
                if (gap_left == 0 && pending_q.size() > 0)
                begin
                    in_data <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    int stall_left = 0;
    out_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = draw_wait();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected transaction", 64'(out_data.position),
                                    64'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.position !== want.position)
                        report_mismatch("position", 64'(out_data.position),
                                        64'(want.position));
                    if (out_data.count !== want.count)
                        report_mismatch("count", 64'(out_data.count), 64'(want.count));
                    if (out_data.corrected_key !== want.corrected_key)
                        report_mismatch("corrected_key", out_data.corrected_key,
                                        want.corrected_key);
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send(logic [1:0] op, logic [63:0] key);
        in_t x;
        x.op = op;
        x.key = key;
        pending_q.push_back(x);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_BYTES)
            cur_kb = val[3:0];
        else
            cur_dist = val;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] mutate(logic [63:0] k);
        int n;
        n = $urandom_range(0, 2 * width_bytes() - 1);
        k[4*n +: 4] = k[4*n +: 4] ^ 4'($urandom_range(1, 15));
        if ($urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(0, 2 * width_bytes() - 1);
            k[4*n +: 4] = k[4*n +: 4] ^ 4'($urandom_range(1, 15));
        end
        return k;
    endfunction

    task automatic random_phase(int n_items);
        logic [63:0] pool[6];
        logic [63:0] mutants[10];
        logic [63:0] k;
        int r;
        int s;
        for (int i = 0; i < 6; i++)
            pool[i] = rand_key();
        for (int i = 0; i < 10; i++)
            mutants[i] = mutate(pool[$urandom_range(0, 5)]);
        for (int i = 0; i < n_items; i++)
        begin
            s = $urandom_range(0, 9);
            if (s < 6)
                k = pool[$urandom_range(0, 5)];
            else if (s < 9)
                k = mutants[$urandom_range(0, 9)];
            else
                k = rand_key();
            r = $urandom_range(0, 99);
            if (r < 56)
                send(OP_INSERT, k);
            else if (r < 90)
                send(OP_QUERY, k);
            else if (r < 92)
                send(OP_CORRECT, k);
            else if (r < 96)
                send(OP_UNUSED, k);
            else
                send(OP_INSERT, rand_key());
        end
        drain();
    endtask

    logic [3:0] kb_list[7] = '{4'd1, 4'd0, 4'd2, 4'd15, 4'd4, 4'd8, 4'd3};
    logic [4:0] dist_list[7] = '{5'd0, 5'd1, 5'd16, 5'd2, 5'd31, 5'd3, 5'd1};
    int fill_n;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_QUERY, 64'h0123_4567_89ab_cdef);
        send(OP_CORRECT, 64'h0);
        send(OP_INSERT, 64'h0);
        send(OP_INSERT, 64'hffff_ffff_ffff_ffff);
        send(OP_INSERT, 64'hffff_ffff_ffff_ffff);
        send(OP_QUERY, 64'hffff_ffff_ffff_ffff);
        send(OP_QUERY, 64'h5);
        send(OP_UNUSED, 64'hffff_ffff_ffff_ffff);
        send(OP_INSERT, 64'h1234_5678_1234_5678);
        send(OP_INSERT, 64'h1234_5678_1234_5679);
        send(OP_INSERT, 64'h1234_5678_1234_5679);
        send(OP_INSERT, 64'h1234_5678_1234_5670);
        send(OP_INSERT, 64'h1234_5678_1234_5600);
        send(OP_CORRECT, 64'h0);
        send(OP_QUERY, 64'h1234_5678_1234_5678);
        send(OP_QUERY, 64'h1234_5678_1234_5670);
        send(OP_QUERY, 64'h1234_5678_1234_5600);
        send(OP_INSERT, 64'h0000_0000_0000_0001);
        send(OP_QUERY, 64'h1234_5678_1234_5678);
        send(OP_QUERY, 64'h0000_0000_0000_0001);
        drain();

        write_reg(REG_MAX_DIST, 5'd0);
        send(OP_CORRECT, 64'h0);
        send(OP_QUERY, 64'h1234_5678_1234_5670);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_KEY_BYTES, {1'($urandom_range(0, 1)), kb_list[ph]});
            write_reg(REG_MAX_DIST, (ph == 6) ? 5'($urandom_range(0, 16)) : dist_list[ph]);
            quiet = (ph == 3);
            random_phase(120);
        end
        quiet = 1'b0;

        write_reg(REG_KEY_BYTES, 5'd24);
        write_reg(REG_MAX_DIST, 5'd16);
        fill_n = CAPACITY - tab_total + 6;
        for (int i = 0; i < fill_n; i++)
            send(OP_INSERT, rand_key());
        drain();
        send(OP_INSERT, tab_key[tab_total / 2]);
        send(OP_QUERY, tab_key[tab_total / 3]);
        send(OP_INSERT, rand_key());
        send(OP_QUERY, rand_key());
        drain();

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
